// File: hdl/max_priority_queue_defines.svh
// assertion macros for the max priority queue
`ifndef MAX_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// checked outside reset
`define MPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mpq assertion failed");

// checked at every edge, reset included
`define MPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mpq assertion failed");

`else

`define MPQ_ASSERT(label, clk, rst, prop)
`define MPQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: hdl/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int DATA_W        = 32;
  localparam int OCC_W         = 5;

  // request codes
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_FRONT = 2'd1,
    REQ_POP   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_go;
    logic scan_run;
    logic shift_go;
    logic shift_run;
    logic commit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    req_t req;
    logic empty;
    logic scan_done;
    logic shift_done;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/mpq_ctrl.sv
`default_nettype none

module mpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  mpq_pkg::sts_t      sts,
  output mpq_pkg::cmd_t      cmd,
  output logic               busy
);
  import mpq_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if ((sts.req == REQ_FRONT || sts.req == REQ_POP) && !sts.empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = (sts.req == REQ_POP) ? S_SHIFT : S_IDLE;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_DECIDE: begin
        if ((sts.req == REQ_FRONT || sts.req == REQ_POP) && !sts.empty) begin
          cmd.scan_go = 1'b1;
        end else begin
          cmd.commit = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.req == REQ_POP) begin
            cmd.shift_go = 1'b1;
          end else begin
            cmd.commit = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (sts.shift_done) cmd.commit = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mpq_dp.sv
`default_nettype none
`include "max_priority_queue_defines.svh"

module mpq_dp #(
  parameter int DEPTH = mpq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [1:0]                  req_type,
  input  wire logic [mpq_pkg::DATA_W-1:0]  push_value,
  input  mpq_pkg::cmd_t                    cmd,
  output mpq_pkg::sts_t                    sts,
  output logic                             done,
  output logic [mpq_pkg::DATA_W-1:0]       max_value,
  output logic [1:0]                       status,
  output logic [mpq_pkg::OCC_W-1:0]        occupancy
);
  import mpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // entry store
  logic [DATA_W-1:0] mem [DEPTH];

  req_t                     req;
  logic [DATA_W-1:0]        val;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            ptr;
  logic                     rd_en;
  logic                     rd_vld;
  logic [AW-1:0]            rd_idx;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] best_val;
  logic [AW-1:0]            best_idx;
  logic                     empty;
  logic                     full;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic                     shift_wr;
  logic                     push_ok;
  logic                     pop_ok;
  stat_t                    res_status;
  logic [DATA_W-1:0]        res_value;
  stat_t                    stat_reg;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  assign sts.req        = req;
  assign sts.empty      = empty;
  assign sts.scan_done  = (ptr == count) && !rd_vld;
  assign sts.shift_done = (ptr == count) && !rd_vld;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req <= req_t'(req_type);
      val <= push_value;
    end
  end

  // scan / shift read pointer and registered read
  assign rd_en = (cmd.scan_run || cmd.shift_run) && (ptr < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (cmd.scan_go || cmd.shift_go) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_go) begin
      ptr <= '0;
    end else if (cmd.shift_go) begin
      ptr <= CW'(best_idx) + CW'(1);
    end else if (rd_en) begin
      ptr <= ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[ptr[AW-1:0]];
      rd_idx  <= ptr[AW-1:0];
    end
  end

  // running maximum, earliest entry wins ties
  always_ff @(posedge clk) begin
    if (cmd.scan_run && rd_vld) begin
      if (rd_idx == '0 || rd_data > best_val) begin
        best_val <= rd_data;
        best_idx <= rd_idx;
      end
    end
  end

  // single write port: gap closing or push
  assign shift_wr = cmd.shift_run && rd_vld;
  assign push_ok  = cmd.commit && (req == REQ_PUSH) && !full;
  assign pop_ok   = cmd.commit && (req == REQ_POP) && !empty;
  assign wr_en    = shift_wr || push_ok;
  assign wr_addr  = shift_wr ? (rd_idx - AW'(1)) : count[AW-1:0];
  assign wr_data  = shift_wr ? rd_data : val;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // result of the request
  always_comb begin
    count_next = count;
    res_status = ST_OK;
    res_value  = '0;
    unique case (req)
      REQ_PUSH: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      REQ_FRONT: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_value = best_val;
        end
      end
      REQ_POP: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_value  = best_val;
          count_next = count - CW'(1);
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      max_value <= res_value;
      stat_reg  <= res_status;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign status = stat_reg;

  `MPQ_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `MPQ_ASSERT(a_shift_index, clk, rst, shift_wr |-> rd_idx != '0)
  `MPQ_ASSERT(a_pop_count, clk, rst, pop_ok |=> count == $past(count) - CW'(1))

endmodule

`default_nettype wire

// File: hdl/max_priority_queue.sv
`default_nettype none
`include "max_priority_queue_defines.svh"

// Max priority queue of signed 32-bit values held in insertion order.
// Command channel: a request (req_type, push_value) transfers at a rising
// edge with start high and busy low. Codes: push, front, pop max, clear.
// Result channel: done is high for exactly one cycle with max_value, status
// and occupancy; the transfer happens at the edge ending that cycle and the
// receiver cannot stall it.
// Push, clear, and front or pop on an empty queue commit without a scan;
// front scans all n entries held, and pop of the maximum at position k (0 at
// the head) then moves the n - 1 - k entries behind it.
// The scan for the maximum reads one entry a cycle through the single read
// port of the entry store into one comparator; pop then moves the later
// entries down one slot a cycle over the same port. One request is handled
// at a time; a new request may transfer in the cycle its predecessor's
// result is shown. Reset empties the queue and drops any request in flight.
module max_priority_queue #(
  parameter int DEPTH = mpq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  req_type,
  input  wire logic [mpq_pkg::DATA_W-1:0]  push_value,
  output logic                             done,
  output logic [mpq_pkg::DATA_W-1:0]       max_value,
  output logic [1:0]                       status,
  output logic [mpq_pkg::OCC_W-1:0]        occupancy
);
  import mpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  mpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // store, comparator and result registers
  mpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_type   (req_type),
    .push_value (push_value),
    .cmd        (cmd),
    .sts        (sts),
    .done       (done),
    .max_value  (max_value),
    .status     (status),
    .occupancy  (occupancy)
  );

  `MPQ_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !done)
  `MPQ_ASSERT(a_done_single, clk, rst, done |=> !done)
  `MPQ_ASSERT(a_done_idle, clk, rst, done |-> !busy)

endmodule

`default_nettype wire
